FILE: hdl/thsg_pkg.sv
// ----------------------------------------------------------------------------
// Three-phase sine table generator package
// Shared widths, reset values and constants for the generator and its checker.
// ----------------------------------------------------------------------------
package thsg_pkg;

    localparam int TABLE_DEPTH  = 128;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LENGTH_W     = 8;
    localparam int SAMPLE_W     = 8;
    localparam int MAG_W        = SAMPLE_W - 1;
    localparam int POS_W        = 7;

    localparam int LENGTH_RESET_INT = 118;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(LENGTH_RESET_INT);
    localparam logic [LENGTH_W-1:0] LENGTH_MAX   = LENGTH_W'(TABLE_DEPTH);
    localparam logic [LENGTH_W-1:0] LENGTH_MIN   = LENGTH_W'(1);

    localparam logic [TABLE_ADDR_W-1:0] THIRD_RESET =
        TABLE_ADDR_W'(LENGTH_RESET_INT / 3);
    localparam logic [TABLE_ADDR_W-1:0] TWO_THIRDS_RESET =
        TABLE_ADDR_W'((2 * LENGTH_RESET_INT) / 3);

    // floor(x / 3) == (x * 171) >> 9 for every x up to 256.
    localparam logic [LENGTH_W-1:0] RECIP_THIRD = LENGTH_W'(171);
    localparam int                  RECIP_SHIFT = 9;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(8'h80);
    localparam logic [MAG_W-1:0]           MAG_MAX    = {MAG_W{1'b1}};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

endpackage

FILE: hdl/three_phase_sine_table_generator.sv
// ----------------------------------------------------------------------------
// Three-phase sine table generator
// Signed wave table with three reads per tick giving magnitude and polarity
// for phases A, B and C spaced a third of the table length apart.
// ----------------------------------------------------------------------------
// Usage
// The input channel (s_) carries write beats (s_op low), which store one table
// entry and give no result, and tick beats (s_op high), which each give one
// result beat on the output channel (m_). One beat is accepted per cycle while s_ready is high.
// An accepted tick passes through the table read register and then the
// magnitude and sign stage into the output register.
// The table is held in three copies so that the three phase reads of a tick
// happen together, which sets the rate at one tick per cycle when not stalled.
// The table length register is written through cfg_we and cfg_wdata; a write
// also clears the position. The thirds of the length are worked out when the
// register is written.
// Reset clears the position, sets the length to 118 and empties the pipeline;
// the table contents are undefined until written.
// When the receiver stalls, the output register holds its beat, the read
// stage holds one more tick, and s_ready then falls until the output moves.
// ----------------------------------------------------------------------------
module three_phase_sine_table_generator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [thsg_pkg::LENGTH_W-1:0]        cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [6:0]                           s_entry_index,
    input  logic signed [thsg_pkg::SAMPLE_W-1:0] s_entry_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [thsg_pkg::POS_W-1:0]           m_position,
    output logic [thsg_pkg::MAG_W-1:0]           m_magnitude_a,
    output logic                                 m_negative_a,
    output logic [thsg_pkg::MAG_W-1:0]           m_magnitude_b,
    output logic                                 m_negative_b,
    output logic [thsg_pkg::MAG_W-1:0]           m_magnitude_c,
    output logic                                 m_negative_c
);
    import thsg_pkg::*;

    logic [LENGTH_W-1:0]     len_reg;
    logic [TABLE_ADDR_W-1:0] third_reg;
    logic [TABLE_ADDR_W-1:0] two_thirds_reg;
    logic [TABLE_ADDR_W-1:0] pos_reg;
    logic [TABLE_ADDR_W-1:0] pos_next;

    logic [LENGTH_W-1:0]     len_eff;
    logic [LENGTH_W:0]       len_double;
    logic [LENGTH_W+LENGTH_W-1:0] third_prod;
    logic [LENGTH_W+LENGTH_W:0]   two_thirds_prod;

    logic [LENGTH_W-1:0]     pa_inc;
    logic [TABLE_ADDR_W-1:0] pa;
    logic [LENGTH_W-1:0]     pa_after;
    logic [LENGTH_W-1:0]     pb_sum;
    logic [LENGTH_W-1:0]     pc_sum;
    logic [TABLE_ADDR_W-1:0] pb;
    logic [TABLE_ADDR_W-1:0] pc;

    logic signed [SAMPLE_W-1:0] mem_a [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] mem_b [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] mem_c [TABLE_DEPTH];

    logic signed [SAMPLE_W-1:0] rd_a_reg;
    logic signed [SAMPLE_W-1:0] rd_b_reg;
    logic signed [SAMPLE_W-1:0] rd_c_reg;
    logic [POS_W-1:0]           rd_pos_reg;
    logic                       rd_valid_reg;
    logic                       m_valid_reg;

    logic out_free;
    logic in_beat;
    logic tick_beat;
    logic write_beat;

    function automatic logic [MAG_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] neg_v;
        neg_v = -v;
        if (v == SAMPLE_MIN) begin
            return MAG_MAX;
        end else if (v[SAMPLE_W-1]) begin
            return neg_v[MAG_W-1:0];
        end else begin
            return v[MAG_W-1:0];
        end
    endfunction

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = !rd_valid_reg || out_free;
    assign in_beat    = s_valid && s_ready;
    assign tick_beat  = in_beat && (op_t'(s_op) == OP_TICK);
    assign write_beat = in_beat && (op_t'(s_op) == OP_WRITE);

    // Length saturation and thirds for the register write.
    always_comb begin
        if (cfg_wdata == '0) begin
            len_eff = LENGTH_MIN;
        end else if (cfg_wdata > LENGTH_MAX) begin
            len_eff = LENGTH_MAX;
        end else begin
            len_eff = cfg_wdata;
        end
        len_double      = {len_eff, 1'b0};
        third_prod      = {{LENGTH_W{1'b0}}, len_eff} * {{LENGTH_W{1'b0}}, RECIP_THIRD};
        two_thirds_prod = {{LENGTH_W{1'b0}}, len_double}
                        * {{LENGTH_W{1'b0}}, 1'b0, RECIP_THIRD};
    end

    // Phase addresses; the position always stays below the length.
    always_comb begin
        pa_inc = {1'b0, pos_reg} + LENGTH_W'(1);
        pa     = (pa_inc == len_reg) ? '0 : pa_inc[TABLE_ADDR_W-1:0];
        pa_after = {1'b0, pa} + LENGTH_W'(1);
        pos_next = (pa_after == len_reg) ? '0 : pa_after[TABLE_ADDR_W-1:0];
        pb_sum = {1'b0, pa} + {1'b0, third_reg};
        pc_sum = {1'b0, pa} + {1'b0, two_thirds_reg};
        pb = (pb_sum >= len_reg) ? TABLE_ADDR_W'(pb_sum - len_reg)
                                 : pb_sum[TABLE_ADDR_W-1:0];
        pc = (pc_sum >= len_reg) ? TABLE_ADDR_W'(pc_sum - len_reg)
                                 : pc_sum[TABLE_ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= LENGTH_RESET;
            third_reg      <= THIRD_RESET;
            two_thirds_reg <= TWO_THIRDS_RESET;
            pos_reg        <= '0;
        end else if (cfg_we) begin
            len_reg        <= len_eff;
            third_reg      <= TABLE_ADDR_W'(third_prod >> RECIP_SHIFT);
            two_thirds_reg <= TABLE_ADDR_W'(two_thirds_prod >> RECIP_SHIFT);
            pos_reg        <= '0;
        end else if (tick_beat) begin
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_beat) begin
            mem_a[s_entry_index[TABLE_ADDR_W-1:0]] <= s_entry_value;
            mem_b[s_entry_index[TABLE_ADDR_W-1:0]] <= s_entry_value;
            mem_c[s_entry_index[TABLE_ADDR_W-1:0]] <= s_entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_beat) begin
            rd_a_reg   <= mem_a[pa];
            rd_b_reg   <= mem_b[pb];
            rd_c_reg   <= mem_c[pc];
            rd_pos_reg <= POS_W'(pa);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                rd_valid_reg <= tick_beat;
            end
            if (out_free) begin
                m_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && rd_valid_reg) begin
            m_position    <= rd_pos_reg;
            m_magnitude_a <= sample_mag(rd_a_reg);
            m_negative_a  <= rd_a_reg[SAMPLE_W-1];
            m_magnitude_b <= sample_mag(rd_b_reg);
            m_negative_b  <= rd_b_reg[SAMPLE_W-1];
            m_magnitude_c <= sample_mag(rd_c_reg);
            m_negative_c  <= rd_c_reg[SAMPLE_W-1];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: hdl/thsg_checker.sv
// ----------------------------------------------------------------------------
// Three-phase sine table generator checker
// Port-level assertions on the generator, attached to it by a bind.
// ----------------------------------------------------------------------------
module thsg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_op,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [thsg_pkg::POS_W-1:0]    m_position,
    input logic [thsg_pkg::MAG_W-1:0]    m_magnitude_a,
    input logic [thsg_pkg::MAG_W-1:0]    m_magnitude_b,
    input logic [thsg_pkg::MAG_W-1:0]    m_magnitude_c
);
    import thsg_pkg::*;

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) &&
        $stable(m_magnitude_a) && $stable(m_magnitude_b) && $stable(m_magnitude_c))
        else $error("stalled result beat changed");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // With the output register empty the input side is never stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Every accepted tick beat is followed by a valid result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (op_t'(s_op) == OP_TICK) |-> ##2 m_valid)
        else $error("tick beat gave no result");

endmodule

bind three_phase_sine_table_generator thsg_checker u_thsg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_op          (s_op),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_position    (m_position),
    .m_magnitude_a (m_magnitude_a),
    .m_magnitude_b (m_magnitude_b),
    .m_magnitude_c (m_magnitude_c)
);
